[rtl/ustc_pkg.sv]
// Shared types, constants and helper functions for the Unix seconds to calendar decoder.
`default_nettype none

package ustc_pkg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NEGATIVE = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    // Seconds of one hour, signed, for the zone offset product.
    localparam logic signed [12:0] SECS_PER_HOUR_S = 13'sd3600;
    localparam logic [16:0]        SECS_PER_HOUR   = 17'd3600;
    localparam logic [16:0]        SECS_PER_DAY    = 17'd86400;

    // First shifted second whose day lies past 3200-01-01 (449249 days * 86400).
    localparam logic [39:0] SEC_LIMIT = 40'd38815113600;

    // 86400 = 2^7 * 675: shift off seven bits, then divide by 675 by reciprocal.
    localparam int          DAY_SHIFT       = 7;
    localparam logic [9:0]  DAY_DIV         = 10'd675;
    localparam logic [28:0] DAY_RECIP       = 29'd407226528;
    localparam int          DAY_RECIP_SHIFT = 38;

    localparam logic [19:0] DAYS_1600_TO_1970 = 20'd135140;
    localparam logic [19:0] LAST_DAY_NUMBER   = 20'd584388;
    localparam logic [19:0] DAYS_400Y         = 20'd146097;
    localparam logic [17:0] DAYS_100Y         = 18'd36524;
    localparam logic [15:0] DAYS_4Y           = 16'd1461;
    localparam logic [10:0] DAYS_1Y           = 11'd365;
    localparam logic [11:0] BASE_YEAR         = 12'd1600;

    // Reciprocals for the small constant divisions.
    localparam logic [12:0] HOUR_RECIP       = 13'd4661;   // /225 on seconds >> 4
    localparam int          HOUR_RECIP_SHIFT = 20;
    localparam logic [10:0] MIN_RECIP        = 11'd1093;   // /15 on seconds >> 2
    localparam int          MIN_RECIP_SHIFT  = 14;
    localparam logic [15:0] C4_RECIP         = 16'd45934;  // /1461
    localparam int          C4_RECIP_SHIFT   = 26;
    localparam logic [12:0] Y100_RECIP       = 13'd5243;   // /100
    localparam int          Y100_RECIP_SHIFT = 19;
    localparam logic [13:0] MOD7_RECIP       = 14'd9363;   // /7
    localparam int          MOD7_RECIP_SHIFT = 16;

    typedef struct packed {
        status_t     status;
        logic [19:0] day_num;   // days counted from 1600
        logic [16:0] sod;       // seconds within the day
    } day_split_t;

    typedef struct packed {
        status_t     status;
        logic [11:0] year;
        logic [8:0]  year_day;
        logic        leap;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } ycal_t;

    typedef struct packed {
        status_t     status;
        logic [11:0] year;
        logic [3:0]  month_index;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic [8:0]  year_day;
    } result_t;

    // floor(3 * (m + 1) / 5) for the shifted month numbers 3 to 14
    function automatic logic [3:0] month_term(input logic [3:0] m);
        logic [3:0] r;
        case (m)
            4'd3:    r = 4'd2;
            4'd4:    r = 4'd3;
            4'd5:    r = 4'd3;
            4'd6:    r = 4'd4;
            4'd7:    r = 4'd4;
            4'd8:    r = 4'd5;
            4'd9:    r = 4'd6;
            4'd10:   r = 4'd6;
            4'd11:   r = 4'd7;
            4'd12:   r = 4'd7;
            4'd13:   r = 4'd8;
            4'd14:   r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/ustc_day_split.sv]
// Offset add, range check and split of the shifted time into day number and second of day.
`default_nettype none

module ustc_day_split
    import ustc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic signed [4:0]  tz_offset_hours,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [39:0] epoch_seconds,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output day_split_t              out_data
);

    logic [3:0] v_reg;
    logic [3:0] v_next;
    logic [3:0] adv;

    always_comb
    begin
        adv[3] = !v_reg[3] || !out_stall;
        for (int k = 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
        v_next[0] = adv[0] ? in_valid : v_reg[0];
        for (int k = 1; k < 4; k++)
        begin
            v_next[k] = adv[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = v_reg[3];

    // Stage 1: add the zone offset
    logic signed [17:0] offset_sec;
    logic signed [40:0] t_next;
    logic signed [40:0] t_reg;

    assign offset_sec = 18'(tz_offset_hours) * 18'(SECS_PER_HOUR_S);
    assign t_next     = 41'(epoch_seconds) + 41'(offset_sec);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            t_reg <= t_next;
        end
    end

    // Stage 2: classify, force second 0 on error, estimate day count
    status_t     s2_status_next;
    logic [35:0] t_eff;
    logic [28:0] s2_x_next;
    logic [57:0] day_prod;
    logic [18:0] s2_qe_next;

    status_t     s2_status_reg;
    logic [28:0] s2_x_reg;
    logic [6:0]  s2_low_reg;
    logic [18:0] s2_qe_reg;

    always_comb
    begin
        if (t_reg[40])
        begin
            s2_status_next = ST_NEGATIVE;
        end
        else if (t_reg[39:0] >= SEC_LIMIT)
        begin
            s2_status_next = ST_RANGE;
        end
        else
        begin
            s2_status_next = ST_OK;
        end
        t_eff      = (s2_status_next == ST_OK) ? t_reg[35:0] : '0;
        s2_x_next  = t_eff[35:DAY_SHIFT];
        day_prod   = 58'(s2_x_next) * 58'(DAY_RECIP);
        s2_qe_next = 19'(day_prod >> DAY_RECIP_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_status_reg <= s2_status_next;
            s2_x_reg      <= s2_x_next;
            s2_low_reg    <= t_eff[DAY_SHIFT-1:0];
            s2_qe_reg     <= s2_qe_next;
        end
    end

    // Stage 3: remainder of the estimate, below twice the divisor
    logic [10:0] s3_r_next;
    status_t     s3_status_reg;
    logic [18:0] s3_qe_reg;
    logic [10:0] s3_r_reg;
    logic [6:0]  s3_low_reg;

    assign s3_r_next = 11'(s2_x_reg - 29'(s2_qe_reg) * 29'(DAY_DIV));

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_status_reg <= s2_status_reg;
            s3_qe_reg     <= s2_qe_reg;
            s3_r_reg      <= s3_r_next;
            s3_low_reg    <= s2_low_reg;
        end
    end

    // Stage 4: correct by one, rebase the day to 1600
    logic        fix;
    logic [18:0] q_days;
    logic [9:0]  r_fixed;
    day_split_t  out_next;
    day_split_t  out_reg;

    always_comb
    begin
        fix              = s3_r_reg >= 11'(DAY_DIV);
        q_days           = s3_qe_reg + 19'(fix);
        r_fixed          = fix ? 10'(s3_r_reg - 11'(DAY_DIV)) : s3_r_reg[9:0];
        out_next.status  = s3_status_reg;
        out_next.day_num = 20'(q_days) + DAYS_1600_TO_1970;
        out_next.sod     = {r_fixed, s3_low_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

    a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.sod < SECS_PER_DAY) && (out_data.day_num <= LAST_DAY_NUMBER)
                      && (out_data.day_num >= DAYS_1600_TO_1970))
        else $error("day split out of range");

endmodule

`default_nettype wire

[rtl/ustc_year_split.sv]
// Year cycles from the day number and hour, minute, second from the second of day.
`default_nettype none

module ustc_year_split
    import ustc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire day_split_t in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output ycal_t           out_data
);

    logic [4:0] v_reg;
    logic [4:0] v_next;
    logic [4:0] adv;

    always_comb
    begin
        adv[4] = !v_reg[4] || !out_stall;
        for (int k = 3; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
        v_next[0] = adv[0] ? in_valid : v_reg[0];
        for (int k = 1; k < 5; k++)
        begin
            v_next[k] = adv[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = v_reg[4];

    // Stage 1: 400-year cycles, hour
    logic [1:0]  c400_next;
    logic [19:0] d1_full;
    logic [25:0] hour_prod;
    status_t     y1_status_reg;
    logic [1:0]  y1_c400_reg;
    logic [17:0] y1_d1_reg;
    logic [16:0] y1_sod_reg;
    logic [4:0]  y1_hh_reg;

    always_comb
    begin
        if (in_data.day_num >= 20'd366 + 20'd3 * DAYS_400Y)
        begin
            c400_next = 2'd3;
        end
        else if (in_data.day_num >= 20'd366 + 20'd2 * DAYS_400Y)
        begin
            c400_next = 2'd2;
        end
        else if (in_data.day_num >= 20'd366 + DAYS_400Y)
        begin
            c400_next = 2'd1;
        end
        else
        begin
            c400_next = 2'd0;
        end
        d1_full   = in_data.day_num - 20'(c400_next) * DAYS_400Y;
        hour_prod = 26'(in_data.sod[16:4]) * 26'(HOUR_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            y1_status_reg <= in_data.status;
            y1_c400_reg   <= c400_next;
            y1_d1_reg     <= d1_full[17:0];
            y1_sod_reg    <= in_data.sod;
            y1_hh_reg     <= 5'(hour_prod >> HOUR_RECIP_SHIFT);
        end
    end

    // Stage 2: 100-year cycles, seconds within the hour
    logic [2:0]  c100_next;
    status_t     y2_status_reg;
    logic [1:0]  y2_c400_reg;
    logic [2:0]  y2_c100_reg;
    logic [15:0] y2_d2_reg;
    logic [4:0]  y2_hh_reg;
    logic [11:0] y2_rem_reg;

    always_comb
    begin
        if (y1_d1_reg >= 18'd1 + 18'd4 * DAYS_100Y)
        begin
            c100_next = 3'd4;
        end
        else if (y1_d1_reg >= 18'd1 + 18'd3 * DAYS_100Y)
        begin
            c100_next = 3'd3;
        end
        else if (y1_d1_reg >= 18'd1 + 18'd2 * DAYS_100Y)
        begin
            c100_next = 3'd2;
        end
        else if (y1_d1_reg >= 18'd1 + DAYS_100Y)
        begin
            c100_next = 3'd1;
        end
        else
        begin
            c100_next = 3'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            y2_status_reg <= y1_status_reg;
            y2_c400_reg   <= y1_c400_reg;
            y2_c100_reg   <= c100_next;
            y2_d2_reg     <= 16'(y1_d1_reg - 18'(c100_next) * DAYS_100Y);
            y2_hh_reg     <= y1_hh_reg;
            y2_rem_reg    <= 12'(y1_sod_reg - 17'(y1_hh_reg) * SECS_PER_HOUR);
        end
    end

    // Stage 3: 4-year cycles (a negative quotient truncates to zero), minute
    logic [15:0] x4;
    logic [31:0] c4_prod;
    logic [20:0] min_prod;
    status_t     y3_status_reg;
    logic [1:0]  y3_c400_reg;
    logic [2:0]  y3_c100_reg;
    logic [4:0]  y3_c4_reg;
    logic [15:0] y3_d2_reg;
    logic [4:0]  y3_hh_reg;
    logic [5:0]  y3_mm_reg;
    logic [11:0] y3_rem_reg;

    always_comb
    begin
        x4       = (y2_d2_reg >= 16'd366) ? y2_d2_reg - 16'd366 : '0;
        c4_prod  = 32'(x4) * 32'(C4_RECIP);
        min_prod = 21'(y2_rem_reg[11:2]) * 21'(MIN_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            y3_status_reg <= y2_status_reg;
            y3_c400_reg   <= y2_c400_reg;
            y3_c100_reg   <= y2_c100_reg;
            y3_c4_reg     <= 5'(c4_prod >> C4_RECIP_SHIFT);
            y3_d2_reg     <= y2_d2_reg;
            y3_hh_reg     <= y2_hh_reg;
            y3_mm_reg     <= 6'(min_prod >> MIN_RECIP_SHIFT);
            y3_rem_reg    <= y2_rem_reg;
        end
    end

    // Stage 4: days within the 4-year cycle, second
    status_t     y4_status_reg;
    logic [1:0]  y4_c400_reg;
    logic [2:0]  y4_c100_reg;
    logic [4:0]  y4_c4_reg;
    logic [10:0] y4_d3_reg;
    logic [4:0]  y4_hh_reg;
    logic [5:0]  y4_mm_reg;
    logic [5:0]  y4_ss_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            y4_status_reg <= y3_status_reg;
            y4_c400_reg   <= y3_c400_reg;
            y4_c100_reg   <= y3_c100_reg;
            y4_c4_reg     <= y3_c4_reg;
            y4_d3_reg     <= 11'(y3_d2_reg - 16'(y3_c4_reg) * DAYS_4Y);
            y4_hh_reg     <= y3_hh_reg;
            y4_mm_reg     <= y3_mm_reg;
            y4_ss_reg     <= 6'(y3_rem_reg - 12'(y3_mm_reg) * 12'd60);
        end
    end

    // Stage 5: single years, leap flag, full year
    logic [2:0]  c1;
    logic [10:0] d4;
    ycal_t       out_next;
    ycal_t       out_reg;

    always_comb
    begin
        out_next = '0;
        if (y4_c100_reg == 3'd4)
        begin
            c1            = 3'd0;
            d4            = y4_d3_reg;
            out_next.leap = 1'b1;
        end
        else if (y4_d3_reg <= 11'd4 * DAYS_1Y)
        begin
            if (y4_d3_reg >= 11'd1 + 11'd3 * DAYS_1Y)
            begin
                c1 = 3'd3;
            end
            else if (y4_d3_reg >= 11'd1 + 11'd2 * DAYS_1Y)
            begin
                c1 = 3'd2;
            end
            else if (y4_d3_reg >= 11'd1 + DAYS_1Y)
            begin
                c1 = 3'd1;
            end
            else
            begin
                c1 = 3'd0;
            end
            d4            = y4_d3_reg - 11'(c1) * DAYS_1Y;
            out_next.leap = 1'b0;
        end
        else
        begin
            c1            = 3'd4;
            d4            = y4_d3_reg - 11'd4 * DAYS_1Y;
            out_next.leap = 1'b1;
        end
        out_next.status   = y4_status_reg;
        out_next.year     = BASE_YEAR + 12'(y4_c400_reg) * 12'd400
                            + 12'(y4_c100_reg) * 12'd100 + 12'(y4_c4_reg) * 12'd4 + 12'(c1);
        out_next.year_day = d4[8:0];
        out_next.hour     = y4_hh_reg;
        out_next.minute   = y4_mm_reg;
        out_next.second   = y4_ss_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

    a_year_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.year_day >= 9'd1) && (out_data.year_day <= 9'd366)
                      && (out_data.hour < 5'd24) && (out_data.minute < 6'd60)
                      && (out_data.second < 6'd60))
        else $error("year split field out of range");

endmodule

`default_nettype wire

[rtl/ustc_month_weekday.sv]
// Month and day of month from the day of year, then the weekday congruence.
`default_nettype none

module ustc_month_weekday
    import ustc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire ycal_t in_data,
    output logic       out_valid,
    input  wire logic  out_stall,
    output result_t    out_data
);

    logic [4:0] v_reg;
    logic [4:0] v_next;
    logic [4:0] adv;

    always_comb
    begin
        adv[4] = !v_reg[4] || !out_stall;
        for (int k = 3; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
        v_next[0] = adv[0] ? in_valid : v_reg[0];
        for (int k = 1; k < 5; k++)
        begin
            v_next[k] = adv[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = v_reg[4];

    // Stage 1: month decode and the shifted month and year of the congruence
    logic [8:0]  dd;
    logic [3:0]  mon;
    logic [3:0]  m_adj;
    logic [11:0] y_adj;
    result_t     m1_res_next;
    result_t     m1_res_reg;
    logic [8:0]  m1_dom_reg;
    logic [3:0]  m1_m_reg;
    logic [11:0] m1_y_reg;

    always_comb
    begin
        dd = in_data.year_day - 9'(in_data.leap);
        if (dd <= 9'd181)
        begin
            if (dd <= 9'd90)
            begin
                if (dd <= 9'd59)
                begin
                    dd = dd + 9'(in_data.leap);
                    if (dd <= 9'd31)
                    begin
                        mon = 4'd0;
                    end
                    else
                    begin
                        dd  = dd - 9'd31;
                        mon = 4'd1;
                    end
                end
                else
                begin
                    dd  = dd - 9'd59;
                    mon = 4'd2;
                end
            end
            else
            begin
                dd = dd - 9'd90;
                if (dd <= 9'd30)
                begin
                    mon = 4'd3;
                end
                else
                begin
                    dd = dd - 9'd30;
                    if (dd <= 9'd31)
                    begin
                        mon = 4'd4;
                    end
                    else
                    begin
                        dd  = dd - 9'd31;
                        mon = 4'd5;
                    end
                end
            end
        end
        else
        begin
            dd = dd - 9'd181;
            if (dd <= 9'd92)
            begin
                if (dd <= 9'd62)
                begin
                    if (dd <= 9'd31)
                    begin
                        mon = 4'd6;
                    end
                    else
                    begin
                        dd  = dd - 9'd31;
                        mon = 4'd7;
                    end
                end
                else
                begin
                    dd  = dd - 9'd62;
                    mon = 4'd8;
                end
            end
            else
            begin
                dd = dd - 9'd92;
                if (dd <= 9'd61)
                begin
                    if (dd <= 9'd31)
                    begin
                        mon = 4'd9;
                    end
                    else
                    begin
                        dd  = dd - 9'd31;
                        mon = 4'd10;
                    end
                end
                else
                begin
                    dd  = dd - 9'd61;
                    mon = 4'd11;
                end
            end
        end

        // January and February count as months 13 and 14 of the year before
        m_adj = mon + 4'd1;
        y_adj = in_data.year;
        if (m_adj <= 4'd2)
        begin
            m_adj = m_adj + 4'd12;
            y_adj = in_data.year - 12'd1;
        end

        m1_res_next              = '0;
        m1_res_next.status       = in_data.status;
        m1_res_next.year         = in_data.year;
        m1_res_next.month_index  = mon;
        m1_res_next.day_of_month = dd[4:0];
        m1_res_next.hour         = in_data.hour;
        m1_res_next.minute       = in_data.minute;
        m1_res_next.second       = in_data.second;
        m1_res_next.year_day     = in_data.year_day;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            m1_res_reg <= m1_res_next;
            m1_dom_reg <= dd;
            m1_m_reg   <= m_adj;
            m1_y_reg   <= y_adj;
        end
    end

    // Stage 2: year / 100
    logic [24:0] y100_prod;
    result_t     m2_res_reg;
    logic [8:0]  m2_dom_reg;
    logic [3:0]  m2_m_reg;
    logic [11:0] m2_y_reg;
    logic [5:0]  m2_y100_reg;

    assign y100_prod = 25'(m1_y_reg) * 25'(Y100_RECIP);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            m2_res_reg  <= m1_res_reg;
            m2_dom_reg  <= m1_dom_reg;
            m2_m_reg    <= m1_m_reg;
            m2_y_reg    <= m1_y_reg;
            m2_y100_reg <= 6'(y100_prod >> Y100_RECIP_SHIFT);
        end
    end

    // Stage 3: congruence sum; y / 400 is (y / 100) / 4
    logic [12:0] sum_next;
    result_t     m3_res_reg;
    logic [12:0] m3_sum_reg;

    assign sum_next = 13'(m2_dom_reg) + 13'({m2_m_reg, 1'b0}) + 13'(month_term(m2_m_reg))
                      + 13'(m2_y_reg) + 13'(m2_y_reg[11:2]) - 13'(m2_y100_reg)
                      + 13'(m2_y100_reg[5:2]) + 13'd1;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            m3_res_reg <= m2_res_reg;
            m3_sum_reg <= sum_next;
        end
    end

    // Stage 4: sum / 7
    logic [26:0] mod7_prod;
    result_t     m4_res_reg;
    logic [12:0] m4_sum_reg;
    logic [9:0]  m4_q7_reg;

    assign mod7_prod = 27'(m3_sum_reg) * 27'(MOD7_RECIP);

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            m4_res_reg <= m3_res_reg;
            m4_sum_reg <= m3_sum_reg;
            m4_q7_reg  <= 10'(mod7_prod >> MOD7_RECIP_SHIFT);
        end
    end

    // Stage 5: remainder is the weekday; output register
    result_t out_next;
    result_t out_reg;

    always_comb
    begin
        out_next         = m4_res_reg;
        out_next.weekday = 3'(m4_sum_reg - 13'(m4_q7_reg) * 13'd7);
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

    a_month_week: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.weekday < 3'd7) && (out_data.month_index < 4'd12)
                      && (out_data.day_of_month >= 5'd1))
        else $error("month or weekday out of range");

endmodule

`default_nettype wire

[rtl/unix_seconds_to_calendar.sv]
// Top level of the Unix seconds to calendar decoder: zone register and the three pipeline parts.
`default_nettype none

// The pipeline has 14 register stages between an accepted item and its result.
// It takes one item per cycle while no stall holds it, with a valid bit per stage.
// A stage loads whenever it is empty or its item moves on, so bubbles close up under stall.
// Reset clears all stage valid bits and loads the zone offset with +8 hours.
// The zone register takes a write in every cycle (cfg_ready is always high).

module unix_seconds_to_calendar
    import ustc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    // zone offset register write
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic signed [4:0]  cfg_data,

    // input items
    input  wire logic               epoch_valid,
    output logic                    epoch_stall,
    input  wire logic signed [39:0] epoch_seconds,

    // result items
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [11:0]             year,
    output logic [3:0]              month_index,
    output logic [4:0]              day_of_month,
    output logic [4:0]              hour,
    output logic [5:0]              minute,
    output logic [5:0]              second,
    output logic [2:0]              weekday,
    output logic [8:0]              year_day,
    output logic [1:0]              status
);

    // Zone offset in whole hours; any 5-bit value is used as written.
    logic signed [4:0] tz_offset_hours_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tz_offset_hours_reg <= 5'sd8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tz_offset_hours_reg <= cfg_data;
        end
    end

    // Part 1: offset, range check, divide by the seconds of a day (4 stages).
    // An out-of-range time is replaced by second 0 here, so the later parts
    // decode 1970-01-01 00:00:00 for it without any special path.
    logic       ds_valid;
    logic       ds_stall;
    day_split_t ds_data;

    ustc_day_split u_day_split (
        .clk             (clk),
        .rst_n           (rst_n),
        .tz_offset_hours (tz_offset_hours_reg),
        .in_valid        (epoch_valid),
        .in_stall        (epoch_stall),
        .epoch_seconds   (epoch_seconds),
        .out_valid       (ds_valid),
        .out_stall       (ds_stall),
        .out_data        (ds_data)
    );

    // Part 2: 400-, 100-, 4- and 1-year cycles in parallel with h:m:s (5 stages).
    logic  ys_valid;
    logic  ys_stall;
    ycal_t ys_data;

    ustc_year_split u_year_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ds_valid),
        .in_stall  (ds_stall),
        .in_data   (ds_data),
        .out_valid (ys_valid),
        .out_stall (ys_stall),
        .out_data  (ys_data)
    );

    // Part 3: month, day of month and weekday (5 stages, last is the output register).
    result_t res;

    ustc_month_weekday u_month_weekday (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ys_valid),
        .in_stall  (ys_stall),
        .in_data   (ys_data),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (res)
    );

    assign year         = res.year;
    assign month_index  = res.month_index;
    assign day_of_month = res.day_of_month;
    assign hour         = res.hour;
    assign minute       = res.minute;
    assign second       = res.second;
    assign weekday      = res.weekday;
    assign year_day     = res.year_day;
    assign status       = res.status;

    // An error item carries the decoding of second 0.
    a_error_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (res.status != ST_OK)) |->
            (year == 12'd1970) && (month_index == 4'd0) && (day_of_month == 5'd1)
            && (hour == 5'd0) && (minute == 6'd0) && (second == 6'd0)
            && (weekday == 3'd4) && (year_day == 9'd1))
        else $error("error item does not decode second 0");

endmodule

`default_nettype wire
